[sv/cbba_pkg.sv]
// shared types, register codes and constants for the content bounding box autocrop block
package cbba_pkg;

  localparam int MAX_WIDTH_DEF  = 2048;
  localparam int MAX_HEIGHT_DEF = 2048;

  localparam int CFG_W   = 12;
  localparam int INDEX_W = 3;
  localparam int CHAN_W  = 8;
  localparam int BOX_W   = 11;
  localparam int SIZE_W  = 12;

  localparam int MIN_THR   = 4;
  localparam int THR_SHIFT = 6;

  localparam logic [CFG_W-1:0]  SIZE_RST         = 12'd2048;
  localparam logic [CHAN_W-1:0] ALPHA_FLOOR_RST  = 8'd16;
  localparam logic [CHAN_W-1:0] BRIGHT_FLOOR_RST = 8'd24;

  localparam logic [INDEX_W-1:0] REG_IMAGE_WIDTH      = 3'd0;
  localparam logic [INDEX_W-1:0] REG_IMAGE_HEIGHT     = 3'd1;
  localparam logic [INDEX_W-1:0] REG_ALPHA_FLOOR      = 3'd2;
  localparam logic [INDEX_W-1:0] REG_BRIGHTNESS_FLOOR = 3'd3;

  typedef struct packed {
    logic [CHAN_W-1:0] pixel_red;
    logic [CHAN_W-1:0] pixel_green;
    logic [CHAN_W-1:0] pixel_blue;
    logic [CHAN_W-1:0] pixel_alpha;
  } pixel_t;

  typedef struct packed {
    logic [BOX_W-1:0]  box_left;
    logic [BOX_W-1:0]  box_right;
    logic [BOX_W-1:0]  box_top;
    logic [BOX_W-1:0]  box_bottom;
    logic [SIZE_W-1:0] crop_width;
    logic [SIZE_W-1:0] crop_height;
    logic              fallback_used;
  } crop_t;

  typedef struct packed {
    logic content;
    logic last_col;
    logic last_row;
    logic row_qual;
  } tag_t;

endpackage

[sv/cbba_fifo.sv]
// small register queue used between front and back and for finished results
module cbba_fifo #(
  parameter int WIDTH = 4,
  parameter int DEPTH = 4
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] din,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] dout,
  output logic             empty
);

  localparam int PW = $clog2(DEPTH);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [PW-1:0]    wptr;
  logic [PW-1:0]    rptr;
  logic [PW:0]      count;
  logic             wr;
  logic             rd;

  assign full  = (count == (PW+1)'(DEPTH));
  assign empty = (count == '0);
  assign wr    = push && !full;
  assign rd    = pop && !empty;
  assign dout  = mem[rptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (wr) wptr <= wptr + PW'(1);
      if (rd) rptr <= rptr + PW'(1);
      if (wr && !rd) count <= count + (PW+1)'(1);
      else if (rd && !wr) count <= count - (PW+1)'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (wr) mem[wptr] <= din;
  end

endmodule

[sv/cbba_front.sv]
// front end: pixel classification, raster position and per-row content count
module cbba_front #(
  parameter int MAX_WIDTH  = cbba_pkg::MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT = cbba_pkg::MAX_HEIGHT_DEF,
  parameter int EW         = $clog2(MAX_WIDTH + 1),
  parameter int EH         = $clog2(MAX_HEIGHT + 1),
  parameter int RCW        = 6
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       restart,
  input  logic [EW-1:0]              eff_w,
  input  logic [EH-1:0]              eff_h,
  input  logic [RCW-1:0]             row_thr,
  input  logic [cbba_pkg::CHAN_W-1:0] alpha_floor,
  input  logic [cbba_pkg::CHAN_W-1:0] brightness_floor,
  input  logic                       accept,
  input  cbba_pkg::pixel_t           pixel,
  output cbba_pkg::tag_t             tag
);

  localparam int COL_W = $clog2(MAX_WIDTH);
  localparam int ROW_W = $clog2(MAX_HEIGHT);

  logic [COL_W-1:0]            col;
  logic [ROW_W-1:0]            row;
  logic [RCW-1:0]              row_count;
  logic [RCW-1:0]              row_count_next;
  logic [cbba_pkg::CHAN_W-1:0] bright;
  logic                        content;

  always_comb begin
    bright = pixel.pixel_red;
    if (pixel.pixel_green > bright) bright = pixel.pixel_green;
    if (pixel.pixel_blue > bright) bright = pixel.pixel_blue;
    content = (pixel.pixel_alpha >= alpha_floor) && (bright > brightness_floor);
    row_count_next = row_count;
    if (content && row_count < row_thr) row_count_next = row_count + RCW'(1);
    tag.content  = content;
    tag.last_col = ((EW'(col) + EW'(1)) == eff_w);
    tag.last_row = ((EH'(row) + EH'(1)) == eff_h);
    tag.row_qual = (row_count_next >= row_thr);
  end

  always_ff @(posedge clk) begin
    if (rst || restart) begin
      col       <= '0;
      row       <= '0;
      row_count <= '0;
    end else if (accept) begin
      if (tag.last_col) begin
        col       <= '0;
        row_count <= '0;
        row       <= tag.last_row ? '0 : row + ROW_W'(1);
      end else begin
        col       <= col + COL_W'(1);
        row_count <= row_count_next;
      end
    end
  end

endmodule

[sv/cbba_back.sv]
// back end: column count read-modify-write, box tracking and result build
module cbba_back #(
  parameter int MAX_WIDTH  = cbba_pkg::MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT = cbba_pkg::MAX_HEIGHT_DEF,
  parameter int EW         = $clog2(MAX_WIDTH + 1),
  parameter int EH         = $clog2(MAX_HEIGHT + 1),
  parameter int CCW        = 6
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             restart,
  input  logic [EW-1:0]    eff_w,
  input  logic [EH-1:0]    eff_h,
  input  logic [CCW-1:0]   col_thr,
  input  logic             mid_empty,
  input  cbba_pkg::tag_t   mid_tag,
  output logic             mid_pop,
  input  logic             res_full,
  output logic             res_push,
  output cbba_pkg::crop_t  res_data
);

  localparam int COL_W = $clog2(MAX_WIDTH);
  localparam int ROW_W = $clog2(MAX_HEIGHT);
  localparam int BW    = cbba_pkg::BOX_W;
  localparam int SW    = cbba_pkg::SIZE_W;

  logic [CCW-1:0]   counts [MAX_WIDTH];
  logic [CCW-1:0]   rd_data;
  logic             fwd;
  logic [CCW-1:0]   fwd_data;

  logic [COL_W-1:0] rd_col;
  logic [ROW_W-1:0] rd_row;

  logic             b_valid;
  cbba_pkg::tag_t   b_tag;
  logic [COL_W-1:0] b_col;
  logic [ROW_W-1:0] b_row;
  logic             b_fire;
  logic             b_end;

  logic             top_found, top_found_next;
  logic [ROW_W-1:0] top_row, top_row_next;
  logic [ROW_W-1:0] bottom_row, bottom_row_next;
  logic [COL_W-1:0] pend_min, pend_min_next;
  logic [COL_W-1:0] pend_max, pend_max_next;
  logic [COL_W-1:0] comm_left, comm_left_next;
  logic [COL_W-1:0] comm_right, comm_right_next;

  logic [CCW-1:0]   cur;
  logic [CCW-1:0]   cnt;
  logic             hit;
  logic [COL_W-1:0] min_upd;
  logic [COL_W-1:0] max_upd;
  logic [BW-1:0]    r_left, r_right, r_top, r_bottom;

  assign b_end    = b_tag.last_col && b_tag.last_row;
  assign b_fire   = b_valid && !(b_end && res_full);
  assign mid_pop  = !mid_empty && (!b_valid || b_fire);
  assign res_push = b_fire && b_end;

  always_comb begin
    cur = fwd ? fwd_data : rd_data;
    if (!top_found) cnt = CCW'(b_tag.content);
    else if (b_tag.content && cur < col_thr) cnt = cur + CCW'(1);
    else cnt = cur;
    hit     = (cnt >= col_thr);
    min_upd = (hit && b_col < pend_min) ? b_col : pend_min;
    max_upd = (hit && b_col > pend_max) ? b_col : pend_max;

    top_found_next  = top_found;
    top_row_next    = top_row;
    bottom_row_next = bottom_row;
    pend_min_next   = min_upd;
    pend_max_next   = max_upd;
    comm_left_next  = comm_left;
    comm_right_next = comm_right;

    if (b_tag.last_col) begin
      if (b_tag.row_qual) begin
        top_found_next  = 1'b1;
        if (!top_found) top_row_next = b_row;
        bottom_row_next = b_row;
        comm_left_next  = min_upd;
        comm_right_next = max_upd;
      end else if (!top_found) begin
        pend_min_next = '1;
        pend_max_next = '0;
      end
    end

    if (top_found_next && comm_left_next <= comm_right_next) begin
      r_left   = BW'(comm_left_next);
      r_right  = BW'(comm_right_next);
      r_top    = BW'(top_row_next);
      r_bottom = BW'(bottom_row_next);
      res_data.fallback_used = 1'b0;
    end else begin
      r_left   = '0;
      r_right  = BW'(eff_w - EW'(1));
      r_top    = '0;
      r_bottom = BW'(eff_h - EH'(1));
      res_data.fallback_used = 1'b1;
    end
    res_data.box_left    = r_left;
    res_data.box_right   = r_right;
    res_data.box_top     = r_top;
    res_data.box_bottom  = r_bottom;
    res_data.crop_width  = SW'(r_right) - SW'(r_left) + SW'(1);
    res_data.crop_height = SW'(r_bottom) - SW'(r_top) + SW'(1);

    if (b_end) begin
      top_found_next  = 1'b0;
      top_row_next    = '0;
      bottom_row_next = '0;
      pend_min_next   = '1;
      pend_max_next   = '0;
      comm_left_next  = '0;
      comm_right_next = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || restart) begin
      b_valid    <= 1'b0;
      rd_col     <= '0;
      rd_row     <= '0;
      top_found  <= 1'b0;
      top_row    <= '0;
      bottom_row <= '0;
      pend_min   <= '1;
      pend_max   <= '0;
      comm_left  <= '0;
      comm_right <= '0;
    end else begin
      if (mid_pop) b_valid <= 1'b1;
      else if (b_fire) b_valid <= 1'b0;
      if (mid_pop) begin
        if (mid_tag.last_col) begin
          rd_col <= '0;
          rd_row <= mid_tag.last_row ? '0 : rd_row + ROW_W'(1);
        end else begin
          rd_col <= rd_col + COL_W'(1);
        end
      end
      if (b_fire) begin
        top_found  <= top_found_next;
        top_row    <= top_row_next;
        bottom_row <= bottom_row_next;
        pend_min   <= pend_min_next;
        pend_max   <= pend_max_next;
        comm_left  <= comm_left_next;
        comm_right <= comm_right_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (mid_pop) begin
      b_tag    <= mid_tag;
      b_col    <= rd_col;
      b_row    <= rd_row;
      rd_data  <= counts[rd_col];
      fwd      <= b_fire && (b_col == rd_col);
      fwd_data <= cnt;
    end
    if (b_fire) counts[b_col] <= cnt;
  end

endmodule

[sv/content_bounding_box_autocrop.sv]
// top level of the content bounding box autocrop block
// Usage: RGBA pixels of one image enter in raster order through a queue-style
// port (push/full); a word is taken when push is high and full is low. After
// the last pixel of an image one result word leaves through empty/pop: the
// box, the crop size and a fallback flag (full image when no box is found).
// Throughput: one pixel per cycle while the result queue has room, set by
// the column count memory (one read and one write per pixel). The last
// pixel's tag passes the four-word queue, then the back-end register.
// A four-word queue sits between the classifying front end and the back end,
// and a two-word queue holds results; when the receiver stalls, the back end
// keeps working until a third result finds the result queue full, then the
// four-word queue fills and full rises.
// Configuration: cfg_write/cfg_index/cfg_data, to be written only while idle
// (the block does not enforce this); any write to a known register restarts the current image.
// Reset: registers go to their defaults, both queues empty, the position and
// detection state clear. The column count memory needs no clearing: each row
// rewrites it until the first qualifying row is seen.
module content_bounding_box_autocrop #(
  parameter int MAX_WIDTH  = cbba_pkg::MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT = cbba_pkg::MAX_HEIGHT_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         push,
  output logic                         full,
  input  cbba_pkg::pixel_t             pixel,
  output logic                         empty,
  input  logic                         pop,
  output cbba_pkg::crop_t              crop,
  input  logic                         cfg_write,
  input  logic [cbba_pkg::INDEX_W-1:0] cfg_index,
  input  logic [cbba_pkg::CFG_W-1:0]   cfg_data
);

  localparam int EW   = $clog2(MAX_WIDTH + 1);
  localparam int EH   = $clog2(MAX_HEIGHT + 1);
  localparam int RCW0 = $clog2(MAX_WIDTH / 64 + 1);
  localparam int CCW0 = $clog2(MAX_HEIGHT / 64 + 1);
  localparam int RCW  = (RCW0 > 3) ? RCW0 : 3;
  localparam int CCW  = (CCW0 > 3) ? CCW0 : 3;
  localparam int CW   = cbba_pkg::CHAN_W;

  logic [cbba_pkg::CFG_W-1:0] image_width;
  logic [cbba_pkg::CFG_W-1:0] image_height;
  logic [CW-1:0]              alpha_floor;
  logic [CW-1:0]              brightness_floor;
  logic                       restart;

  logic [EW-1:0]  eff_w;
  logic [EH-1:0]  eff_h;
  logic [EW-1:0]  w_div;
  logic [EH-1:0]  h_div;
  logic [RCW-1:0] row_thr;
  logic [CCW-1:0] col_thr;

  logic            accept;
  cbba_pkg::tag_t  front_tag;
  cbba_pkg::tag_t  mid_tag;
  logic            mid_full;
  logic            mid_empty;
  logic            mid_pop;
  logic            res_full;
  logic            res_push;
  cbba_pkg::crop_t res_data;

  always_comb begin
    restart = 1'b0;
    if (cfg_write) begin
      unique case (cfg_index)
        cbba_pkg::REG_IMAGE_WIDTH,
        cbba_pkg::REG_IMAGE_HEIGHT,
        cbba_pkg::REG_ALPHA_FLOOR,
        cbba_pkg::REG_BRIGHTNESS_FLOOR: restart = 1'b1;
        default: restart = 1'b0;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      image_width      <= cbba_pkg::SIZE_RST;
      image_height     <= cbba_pkg::SIZE_RST;
      alpha_floor      <= cbba_pkg::ALPHA_FLOOR_RST;
      brightness_floor <= cbba_pkg::BRIGHT_FLOOR_RST;
    end else if (cfg_write) begin
      unique case (cfg_index)
        cbba_pkg::REG_IMAGE_WIDTH:      image_width      <= cfg_data;
        cbba_pkg::REG_IMAGE_HEIGHT:     image_height     <= cfg_data;
        cbba_pkg::REG_ALPHA_FLOOR:      alpha_floor      <= cfg_data[CW-1:0];
        cbba_pkg::REG_BRIGHTNESS_FLOOR: brightness_floor <= cfg_data[CW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    if (image_width == '0) eff_w = EW'(1);
    else if (32'(image_width) > MAX_WIDTH) eff_w = EW'(MAX_WIDTH);
    else eff_w = EW'(image_width);
    if (image_height == '0) eff_h = EH'(1);
    else if (32'(image_height) > MAX_HEIGHT) eff_h = EH'(MAX_HEIGHT);
    else eff_h = EH'(image_height);
    w_div = eff_w >> cbba_pkg::THR_SHIFT;
    h_div = eff_h >> cbba_pkg::THR_SHIFT;
    row_thr = (32'(w_div) > cbba_pkg::MIN_THR) ? RCW'(w_div) : RCW'(cbba_pkg::MIN_THR);
    col_thr = (32'(h_div) > cbba_pkg::MIN_THR) ? CCW'(h_div) : CCW'(cbba_pkg::MIN_THR);
  end

  assign full   = mid_full;
  assign accept = push && !mid_full;

  cbba_front #(
    .MAX_WIDTH (MAX_WIDTH),
    .MAX_HEIGHT(MAX_HEIGHT),
    .EW        (EW),
    .EH        (EH),
    .RCW       (RCW)
  ) u_front (
    .clk             (clk),
    .rst             (rst),
    .restart         (restart),
    .eff_w           (eff_w),
    .eff_h           (eff_h),
    .row_thr         (row_thr),
    .alpha_floor     (alpha_floor),
    .brightness_floor(brightness_floor),
    .accept          (accept),
    .pixel           (pixel),
    .tag             (front_tag)
  );

  cbba_fifo #(
    .WIDTH($bits(cbba_pkg::tag_t)),
    .DEPTH(4)
  ) u_mid_q (
    .clk  (clk),
    .rst  (rst),
    .push (accept),
    .din  (front_tag),
    .full (mid_full),
    .pop  (mid_pop),
    .dout (mid_tag),
    .empty(mid_empty)
  );

  cbba_back #(
    .MAX_WIDTH (MAX_WIDTH),
    .MAX_HEIGHT(MAX_HEIGHT),
    .EW        (EW),
    .EH        (EH),
    .CCW       (CCW)
  ) u_back (
    .clk      (clk),
    .rst      (rst),
    .restart  (restart),
    .eff_w    (eff_w),
    .eff_h    (eff_h),
    .col_thr  (col_thr),
    .mid_empty(mid_empty),
    .mid_tag  (mid_tag),
    .mid_pop  (mid_pop),
    .res_full (res_full),
    .res_push (res_push),
    .res_data (res_data)
  );

  cbba_fifo #(
    .WIDTH($bits(cbba_pkg::crop_t)),
    .DEPTH(2)
  ) u_res_q (
    .clk  (clk),
    .rst  (rst),
    .push (res_push),
    .din  (res_data),
    .full (res_full),
    .pop  (pop),
    .dout (crop),
    .empty(empty)
  );

endmodule

[sv/cbba_checker.sv]
// port-level checks on result words of the autocrop block, bound to the top level
module cbba_checker (
  input logic            clk,
  input logic            rst,
  input logic            pop,
  input logic            empty,
  input cbba_pkg::crop_t crop
);

  localparam int SW = cbba_pkg::SIZE_W;

  a_empty_after_reset: assert property (@(posedge clk) rst |=> empty)
    else $error("result queue not empty after reset");

  a_crop_width: assert property (@(posedge clk) disable iff (rst)
    !empty |-> crop.crop_width ==
      (SW'(crop.box_right) - SW'(crop.box_left) + SW'(1)))
    else $error("crop width does not match box");

  a_crop_height: assert property (@(posedge clk) disable iff (rst)
    !empty |-> crop.crop_height ==
      (SW'(crop.box_bottom) - SW'(crop.box_top) + SW'(1)))
    else $error("crop height does not match box");

  a_box_order: assert property (@(posedge clk) disable iff (rst)
    !empty |-> (crop.box_left <= crop.box_right) && (crop.box_top <= crop.box_bottom))
    else $error("box edges out of order");

  a_result_holds: assert property (@(posedge clk) disable iff (rst)
    !empty && !pop |=> !empty && $stable(crop))
    else $error("waiting result changed");

endmodule

bind content_bounding_box_autocrop cbba_checker u_cbba_checker (
  .clk  (clk),
  .rst  (rst),
  .pop  (pop),
  .empty(empty),
  .crop (crop)
);
